// File: rtl/lpst_pkg.sv
// Shared types and constants for the linked piece set table.
// Holds command, status and sequencer codes and the free-map control structs.
// No dependencies.
package lpst_pkg;

    // Packed entry: row in bits 2..0, column in bits 5..3, identifier in bits 13..6.
    localparam int KEY_W   = 14;
    localparam int SLOT_W  = 5;
    localparam int IN_W    = 16;
    localparam int OUT_W   = 8;

    typedef enum logic [1:0] {
        CMD_FIND   = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_POOL_FULL = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_WALK  = 2'd1,
        S_APPLY = 2'd2
    } state_t;

    typedef struct packed {
        logic start;
        logic mark_used;
        logic mark_free;
        logic clear_all;
    } free_ctl_t;

    typedef struct packed {
        logic done;
        logic found;
    } free_sts_t;

endpackage

// File: rtl/lpst_ram.sv
// Simple dual-port synchronous RAM with one write and one registered read port.
// Used for the entry store and the next-link store. No package dependencies.
module lpst_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 14,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/lpst_free_map.sv
// Slot occupancy map and lowest-free-slot scanner for the piece set table.
// One occupancy bit per slot in flip-flops; the scan tests one slot per cycle.
// Depends on lpst_pkg.
module lpst_free_map
    import lpst_pkg::*;
#(
    parameter int POOL_SLOTS = 32,
    localparam int IW = $clog2(POOL_SLOTS)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  free_ctl_t       ctl,
    input  logic [IW-1:0]   mark_idx,
    output free_sts_t       sts,
    output logic [IW-1:0]   free_idx
);

    logic [POOL_SLOTS-1:0] used_reg, used_next;
    logic [IW:0]           idx_reg, idx_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic                  found_reg, found_next;

    always_comb
    begin
        used_next  = used_reg;
        idx_next   = idx_reg;
        busy_next  = busy_reg;
        done_next  = done_reg;
        found_next = found_reg;

        if (ctl.start)
        begin
            idx_next   = '0;
            busy_next  = 1'b1;
            done_next  = 1'b0;
            found_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (idx_reg == (IW+1)'(POOL_SLOTS))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (!used_reg[idx_reg[IW-1:0]])
            begin
                busy_next  = 1'b0;
                done_next  = 1'b1;
                found_next = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end

        // Any change to occupancy makes an earlier scan result stale.
        if (ctl.mark_used)
        begin
            used_next[mark_idx] = 1'b1;
            done_next           = 1'b0;
        end
        if (ctl.mark_free)
        begin
            used_next[mark_idx] = 1'b0;
            done_next           = 1'b0;
        end
        if (ctl.clear_all)
        begin
            used_next = '0;
            done_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            idx_reg   <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            used_reg  <= used_next;
            idx_reg   <= idx_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            found_reg <= found_next;
        end
    end

    assign sts.done  = done_reg;
    assign sts.found = found_reg;
    assign free_idx  = idx_reg[IW-1:0];

    // A reported free slot really is free.
    a_found_is_free: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && found_reg) |-> !used_reg[idx_reg[IW-1:0]])
        else $error("scanner reported an occupied slot as free");

    // A slot is only ever taken while it is free.
    a_take_free_only: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.mark_used |-> !used_reg[mark_idx])
        else $error("occupied slot taken a second time");

    // Clearing empties the whole map in the cycle after it is asked for.
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear_all |=> (used_reg == '0))
        else $error("occupancy map not empty after clear");

endmodule

// File: rtl/lpst_ctrl.sv
// Command sequencer for the piece set table: chain walk, list update, result register.
// Drives both RAMs and the free map. Depends on lpst_pkg.
module lpst_ctrl
    import lpst_pkg::*;
#(
    parameter int POOL_SLOTS = 32,
    localparam int IW = $clog2(POOL_SLOTS)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [IN_W-1:0]    s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [OUT_W-1:0]   m_tdata,
    // entry RAM
    output logic               entry_we,
    output logic [IW-1:0]      entry_waddr,
    output logic [KEY_W-1:0]   entry_wdata,
    input  logic [KEY_W-1:0]   entry_q,
    // link RAM
    output logic               link_we,
    output logic [IW-1:0]      link_waddr,
    output logic [IW-1:0]      link_wdata,
    input  logic [IW-1:0]      link_q,
    // shared read port control for both RAMs
    output logic               rd_en,
    output logic [IW-1:0]      rd_addr,
    // free map
    output free_ctl_t          free_ctl,
    output logic [IW-1:0]      mark_idx,
    input  free_sts_t          free_sts,
    input  logic [IW-1:0]      free_idx
);

    state_t             state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [IW-1:0]      cur_reg, cur_next;
    logic [IW-1:0]      prev_reg, prev_next;
    logic               prev_valid_reg, prev_valid_next;
    logic               found_reg, found_next;
    logic [IW-1:0]      hit_reg, hit_next;
    logic               hit_tail_reg, hit_tail_next;
    logic [IW-1:0]      nxt_reg, nxt_next;
    logic [IW-1:0]      head_reg, head_next;
    logic [IW-1:0]      tail_reg, tail_next;
    logic               empty_reg, empty_next;
    status_t            status_reg, status_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic               m_valid_reg, m_valid_next;

    logic               accept;
    logic               match;
    logic               walk_end;
    logic               out_free;
    logic               apply_go;
    logic [IW-1:0]      res_idx;
    logic [IW+SLOT_W-1:0] res_wide;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign match    = (entry_q == key_reg);
    assign walk_end = match || (cur_reg == tail_reg);
    assign out_free = !m_valid_reg || m_tready;
    assign apply_go = out_free &&
                      !((cmd_reg == CMD_ADD) && !found_reg && !free_sts.done);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if ((cmd_t'(s_tdata[1:0]) == CMD_CLEAR) || empty_reg)
                    begin
                        state_next = S_APPLY;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                if (walk_end)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (apply_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and memory controls
    always_comb
    begin
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        prev_valid_next = prev_valid_reg;
        found_next      = found_reg;
        hit_next        = hit_reg;
        hit_tail_next   = hit_tail_reg;
        nxt_next        = nxt_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        empty_next      = empty_reg;
        status_next     = status_reg;
        slot_next       = slot_reg;
        m_valid_next    = m_valid_reg && !m_tready;

        entry_we    = 1'b0;
        entry_waddr = free_idx;
        entry_wdata = key_reg;
        link_we     = 1'b0;
        link_waddr  = tail_reg;
        link_wdata  = free_idx;
        rd_en       = 1'b0;
        rd_addr     = head_reg;
        free_ctl    = '0;
        mark_idx    = free_idx;
        res_idx     = '0;
        res_wide    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next        = cmd_t'(s_tdata[1:0]);
                    key_next        = s_tdata[IN_W-1:2];
                    cur_next        = head_reg;
                    prev_valid_next = 1'b0;
                    found_next      = 1'b0;
                    rd_en           = !empty_reg;
                    rd_addr         = head_reg;
                    free_ctl.start  = 1'b1;
                end
            end
            S_WALK:
            begin
                if (match)
                begin
                    found_next    = 1'b1;
                    hit_next      = cur_reg;
                    hit_tail_next = (cur_reg == tail_reg);
                    nxt_next      = link_q;
                end
                else if (cur_reg != tail_reg)
                begin
                    rd_en           = 1'b1;
                    rd_addr         = link_q;
                    prev_next       = cur_reg;
                    prev_valid_next = 1'b1;
                    cur_next        = link_q;
                end
            end
            S_APPLY:
            begin
                if (apply_go)
                begin
                    status_next = ST_DONE;
                    case (cmd_reg)
                        CMD_FIND:
                        begin
                            if (found_reg)
                            begin
                                res_idx = hit_reg;
                            end
                            else
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                        end
                        CMD_ADD:
                        begin
                            if (found_reg)
                            begin
                                status_next = ST_DUPLICATE;
                            end
                            else if (!free_sts.found)
                            begin
                                status_next = ST_POOL_FULL;
                            end
                            else
                            begin
                                link_we            = !empty_reg;
                                link_waddr         = tail_reg;
                                link_wdata         = free_idx;
                                entry_we           = 1'b1;
                                head_next          = empty_reg ? free_idx : head_reg;
                                tail_next          = free_idx;
                                empty_next         = 1'b0;
                                free_ctl.mark_used = 1'b1;
                                mark_idx           = free_idx;
                                res_idx            = free_idx;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (!found_reg)
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                            else
                            begin
                                if (prev_valid_reg)
                                begin
                                    if (hit_tail_reg)
                                    begin
                                        tail_next = prev_reg;
                                    end
                                    else
                                    begin
                                        link_we    = 1'b1;
                                        link_waddr = prev_reg;
                                        link_wdata = nxt_reg;
                                    end
                                end
                                else if (hit_tail_reg)
                                begin
                                    empty_next = 1'b1;
                                end
                                else
                                begin
                                    head_next = nxt_reg;
                                end
                                free_ctl.mark_free = 1'b1;
                                mark_idx           = hit_reg;
                                res_idx            = hit_reg;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            free_ctl.clear_all = 1'b1;
                            empty_next         = 1'b1;
                        end
                        default:
                        begin
                            status_next = ST_DONE;
                        end
                    endcase
                    res_wide     = (IW+SLOT_W)'(res_idx);
                    slot_next    = res_wide[SLOT_W-1:0];
                    m_valid_next = 1'b1;
                end
            end
            default:
            begin
                m_valid_next = m_valid_reg && !m_tready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            empty_reg      <= 1'b1;
            m_valid_reg    <= 1'b0;
            found_reg      <= 1'b0;
            prev_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            empty_reg      <= empty_next;
            m_valid_reg    <= m_valid_next;
            found_reg      <= found_next;
            prev_valid_reg <= prev_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        hit_reg      <= hit_next;
        hit_tail_reg <= hit_tail_next;
        nxt_reg      <= nxt_next;
        head_reg     <= head_next;
        tail_reg     <= tail_next;
        status_reg   <= status_next;
        slot_reg     <= slot_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, slot_reg, status_reg};

    // The chain is only walked when the list holds something.
    a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> !empty_reg)
        else $error("chain walk started on an empty list");

    // A walk step never links a slot to itself.
    a_no_self_link: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && prev_valid_reg) |-> (prev_reg != cur_reg))
        else $error("chain walk revisited the same slot");

    // A successful add always leaves a non-empty list behind.
    a_add_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY && apply_go && cmd_reg == CMD_ADD && !found_reg
         && free_sts.found) |=> !empty_reg)
        else $error("list still empty after a successful add");

endmodule

// File: rtl/linked_piece_set_table.sv
// Linked piece set table: a pool of POOL_SLOTS slots holding (row, column,
// identifier) entries chained in insertion order. Each command transfer on the
// slave side gives exactly one result transfer on the master side. A find or a
// remove walks the chain from the head and reads the entry and link RAMs once
// per visited slot; the read latency is hidden by steering the next read
// address straight from the returned link. An add walks the chain for
// duplicates while the free map tests one slot per cycle for the lowest free
// one, in parallel; a new entry waits for the longer of the two searches. A
// clear needs no pass over the slots, as occupancy lives in flip-flops and is
// wiped at once, so no clearing pass is needed after reset either. A new
// command is taken while the previous result still waits in the output
// register; only its completion waits for that register to free up. The
// status code reports done, not found, duplicate ignored or pool full, and the
// slot index is zero whenever the status is not done. With more than 32 slots
// only the low five bits of the slot number are reported.
// Depends on lpst_pkg, lpst_ram, lpst_free_map and lpst_ctrl.
module linked_piece_set_table
    import lpst_pkg::*;
#(
    parameter int POOL_SLOTS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // cmd[1:0], piece_row[4:2], piece_col[7:5], piece_id[15:8]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // status[1:0], slot_index[6:2], zero[7]
);

    localparam int IW = $clog2(POOL_SLOTS);

    logic               entry_we;
    logic [IW-1:0]      entry_waddr;
    logic [KEY_W-1:0]   entry_wdata;
    logic [KEY_W-1:0]   entry_q;
    logic               link_we;
    logic [IW-1:0]      link_waddr;
    logic [IW-1:0]      link_wdata;
    logic [IW-1:0]      link_q;
    logic               rd_en;
    logic [IW-1:0]      rd_addr;
    free_ctl_t          free_ctl;
    free_sts_t          free_sts;
    logic [IW-1:0]      mark_idx;
    logic [IW-1:0]      free_idx;

    // Sequencer: accepts commands, walks the chain and commits the list update.
    lpst_ctrl #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .entry_we    (entry_we),
        .entry_waddr (entry_waddr),
        .entry_wdata (entry_wdata),
        .entry_q     (entry_q),
        .link_we     (link_we),
        .link_waddr  (link_waddr),
        .link_wdata  (link_wdata),
        .link_q      (link_q),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .free_ctl    (free_ctl),
        .mark_idx    (mark_idx),
        .free_sts    (free_sts),
        .free_idx    (free_idx)
    );

    // Entry store: packed key of each slot, only read for chained slots.
    lpst_ram #(
        .DEPTH (POOL_SLOTS),
        .WIDTH (KEY_W)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (entry_we),
        .wr_addr (entry_waddr),
        .wr_data (entry_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (entry_q)
    );

    // Link store: next slot of each chained slot other than the tail.
    lpst_ram #(
        .DEPTH (POOL_SLOTS),
        .WIDTH (IW)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (link_we),
        .wr_addr (link_waddr),
        .wr_data (link_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (link_q)
    );

    // Occupancy bits stand for the free marks; the scanner finds the lowest free slot.
    lpst_free_map #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_free_map (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (free_ctl),
        .mark_idx (mark_idx),
        .sts      (free_sts),
        .free_idx (free_idx)
    );

endmodule

// File: bench/tb_linked_piece_set_table.sv
// Self-checking bench for the linked piece set table: directed and random command traffic.
// Keeps its own model of the slot chain to predict every result transfer.
// Depends on lpst_pkg and linked_piece_set_table.
`timescale 1ns / 100ps

module tb_linked_piece_set_table;
    import lpst_pkg::*;

    localparam int SLOTS = 32;
    // Link codes of the bench's own chain model: one past the last slot ends the chain,
    // the code after that marks an unused slot.
    localparam logic [5:0] CHAIN_END   = 6'd32;
    localparam logic [5:0] SLOT_UNUSED = 6'd33;

    typedef struct packed {
        status_t    st;
        logic [4:0] idx;
    } table_reply_t;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;   // cmd[1:0], piece_row[4:2], piece_col[7:5], piece_id[15:8]
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;   // status[1:0], slot_index[6:2], zero[7]

    // Model of the table: next link per slot, the packed piece held in it, and the
    // two ends of the chain.
    logic [5:0]       nxt_of   [SLOTS];
    logic [KEY_W-1:0] piece_at [SLOTS];
    logic [5:0]       first_slot;
    logic [5:0]       last_slot;

    table_reply_t pending_replies[$];
    int           mismatch_count = 0;
    int           send_idle_pct  = 0;
    int           recv_idle_pct  = 0;
    int           hold_request   = 0;
    int           stall_left     = 0;

    linked_piece_set_table #(
        .POOL_SLOTS(SLOTS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Guard against a hung block; the slowest legal run is far shorter than this.
    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic bit is_chained(logic [5:0] v);
        return v < SLOTS;
    endfunction

    function automatic logic [KEY_W-1:0] piece(logic [2:0] row, logic [2:0] col,
                                               logic [7:0] id);
        return {id, col, row};
    endfunction

    function automatic int slots_in_use();
        int n;
        int i;
        n = 0;
        for (i = 0; i < SLOTS; i++)
            if (nxt_of[i] != SLOT_UNUSED)
                n++;
        return n;
    endfunction

    task automatic reset_table_model();
        int i;
        for (i = 0; i < SLOTS; i++)
        begin
            nxt_of[i]   = SLOT_UNUSED;
            piece_at[i] = '0;
        end
        first_slot = CHAIN_END;
        last_slot  = CHAIN_END;
    endtask

    // Walks the chain from the head, at most one visit per slot. Gives the matching
    // slot and the one before it, or the end code for both when nothing matches.
    task automatic search_chain(input logic [KEY_W-1:0] key, output logic [5:0] hit,
                                output logic [5:0] pred);
        logic [5:0] cur;
        logic [5:0] back;
        int         n;
        cur  = first_slot;
        back = CHAIN_END;
        hit  = CHAIN_END;
        pred = CHAIN_END;
        for (n = 0; n < SLOTS && is_chained(cur) && hit == CHAIN_END; n++)
        begin
            if (piece_at[cur[4:0]] == key)
            begin
                hit  = cur;
                pred = back;
            end
            else
            begin
                back = cur;
                cur  = nxt_of[cur[4:0]];
            end
        end
    endtask

    // Applies one command to the model and gives the result it must produce.
    task automatic apply_command(input cmd_t c, input logic [KEY_W-1:0] key,
                                 output table_reply_t reply);
        logic [5:0] hit;
        logic [5:0] pred;
        logic [5:0] fresh;
        logic [5:0] follow;
        int         i;
        reply.st  = ST_DONE;
        reply.idx = '0;
        case (c)
            CMD_FIND:
            begin
                search_chain(key, hit, pred);
                if (is_chained(hit))
                    reply.idx = hit[4:0];
                else
                    reply.st = ST_NOT_FOUND;
            end
            CMD_ADD:
            begin
                search_chain(key, hit, pred);
                if (is_chained(hit))
                    reply.st = ST_DUPLICATE;
                else
                begin
                    fresh = CHAIN_END;
                    for (i = SLOTS - 1; i >= 0; i--)
                        if (nxt_of[i] == SLOT_UNUSED)
                            fresh = 6'(i);
                    if (!is_chained(fresh))
                        reply.st = ST_POOL_FULL;
                    else
                    begin
                        if (is_chained(first_slot) && is_chained(last_slot))
                            nxt_of[last_slot[4:0]] = fresh;
                        else
                            first_slot = fresh;
                        nxt_of[fresh[4:0]]   = CHAIN_END;
                        piece_at[fresh[4:0]] = key;
                        last_slot            = fresh;
                        reply.idx            = fresh[4:0];
                    end
                end
            end
            CMD_REMOVE:
            begin
                search_chain(key, hit, pred);
                if (!is_chained(hit))
                    reply.st = ST_NOT_FOUND;
                else
                begin
                    follow = nxt_of[hit[4:0]];
                    if (is_chained(pred))
                    begin
                        nxt_of[pred[4:0]] = follow;
                        if (hit == last_slot)
                        begin
                            last_slot         = pred;
                            nxt_of[pred[4:0]] = CHAIN_END;
                        end
                    end
                    else
                    begin
                        // Unlinking the head; the only entry leaves both ends empty.
                        first_slot = is_chained(follow) ? follow : CHAIN_END;
                        if (hit == last_slot)
                            last_slot = CHAIN_END;
                    end
                    nxt_of[hit[4:0]] = SLOT_UNUSED;
                    reply.idx        = hit[4:0];
                end
            end
            default:
            begin
                for (i = 0; i < SLOTS; i++)
                    nxt_of[i] = SLOT_UNUSED;
                first_slot = CHAIN_END;
                last_slot  = CHAIN_END;
            end
        endcase
        if (reply.st != ST_DONE)
            reply.idx = '0;
    endtask

    // Draws a piece; with the given chance it is one that is chained at present, so
    // that finds and removes hit and adds see duplicates.
    function automatic logic [KEY_W-1:0] choose_key(int hit_pct);
        logic [KEY_W-1:0] key;
        int               start;
        int               k;
        key = piece(3'($urandom_range(7)), 3'($urandom_range(7)), 8'($urandom_range(255)));
        if (slots_in_use() > 0 && $urandom_range(99) < hit_pct)
        begin
            start = $urandom_range(SLOTS - 1);
            for (k = 0; k < SLOTS; k++)
            begin
                if (nxt_of[(start + k) % SLOTS] != SLOT_UNUSED)
                begin
                    key = piece_at[(start + k) % SLOTS];
                    break;
                end
            end
        end
        return key;
    endfunction

    // Offers one command transfer, after a random idle gap, and records the
    // predicted result once the block has taken it. Valid stays high after the
    // transfer; the next call either reloads it or lowers it for a gap.
    task automatic send_piece(input cmd_t c, input logic [KEY_W-1:0] key);
        table_reply_t reply;
        int           gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {key, c};
        do
            @(posedge clk);
        while (!s_tready);
        apply_command(c, key, reply);
        pending_replies.push_back(reply);
    endtask

    task automatic wait_for_replies();
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_reply(input logic [OUT_W-1:0] data);
        table_reply_t want;
        if (pending_replies.size() == 0)
        begin
            $display("%0t: result transfer with nothing expected, got %h", $time, data);
            mismatch_count++;
        end
        else
        begin
            want = pending_replies.pop_front();
            if (data[1:0] !== want.st)
            begin
                $display("%0t: status expected %0d, got %0d", $time, want.st, data[1:0]);
                mismatch_count++;
            end
            if (data[6:2] !== want.idx)
            begin
                $display("%0t: slot_index expected %0d, got %0d", $time, want.idx, data[6:2]);
                mismatch_count++;
            end
            if (data[7] !== 1'b0)
            begin
                $display("%0t: padding bit expected 0, got %b", $time, data[7]);
                mismatch_count++;
            end
        end
    endtask

    // Result side: checks every transfer and decides the ready level for the next
    // cycle. A long hold-off asked for by a test is counted down here.
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            check_reply(m_tdata);
        if (hold_request != 0)
        begin
            stall_left   = hold_request;
            hold_request = 0;
        end
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Find and remove on an empty list both miss; clear on an empty list is done.
    task automatic test_empty_table();
        send_piece(CMD_FIND, piece(3'd1, 3'd2, 8'd3));
        send_piece(CMD_REMOVE, piece(3'd1, 3'd2, 8'd3));
        send_piece(CMD_CLEAR, piece(3'd7, 3'd7, 8'hFF));
    endtask

    // One entry at a time, at both extremes of the fields: duplicate refused, the
    // only entry removed cleanly, and its slot handed out again.
    task automatic test_single_entry();
        send_piece(CMD_ADD, piece(3'd0, 3'd0, 8'h00));
        send_piece(CMD_FIND, piece(3'd0, 3'd0, 8'h00));
        send_piece(CMD_ADD, piece(3'd0, 3'd0, 8'h00));
        send_piece(CMD_REMOVE, piece(3'd0, 3'd0, 8'h00));
        send_piece(CMD_FIND, piece(3'd0, 3'd0, 8'h00));
        send_piece(CMD_ADD, piece(3'd7, 3'd7, 8'hFF));
        send_piece(CMD_REMOVE, piece(3'd7, 3'd7, 8'hFF));
    endtask

    // Several entries: removing the tail, the head and a middle slot, and checking
    // that freed slots are reused lowest first and appended at the tail.
    task automatic test_chain_order();
        send_piece(CMD_ADD, piece(3'd7, 3'd0, 8'hAA));
        send_piece(CMD_ADD, piece(3'd0, 3'd7, 8'h55));
        send_piece(CMD_ADD, piece(3'd3, 3'd4, 8'hFF));
        send_piece(CMD_REMOVE, piece(3'd3, 3'd4, 8'hFF));
        send_piece(CMD_FIND, piece(3'd0, 3'd7, 8'h55));
        send_piece(CMD_ADD, piece(3'd3, 3'd4, 8'hFF));
        send_piece(CMD_REMOVE, piece(3'd7, 3'd0, 8'hAA));
        send_piece(CMD_ADD, piece(3'd5, 3'd2, 8'h01));
        send_piece(CMD_REMOVE, piece(3'd3, 3'd4, 8'hFF));
        send_piece(CMD_FIND, piece(3'd5, 3'd2, 8'h01));
        send_piece(CMD_FIND, piece(3'd5, 3'd2, 8'h02));
        send_piece(CMD_CLEAR, '0);
        send_piece(CMD_FIND, piece(3'd0, 3'd7, 8'h55));
    endtask

    // Fills every slot, then an add is refused as pool full while a duplicate is
    // still reported as such; a freed middle slot is taken by the next add.
    task automatic test_pool_full();
        int i;
        for (i = 0; i < SLOTS; i++)
            send_piece(CMD_ADD, piece(3'(i), 3'(i >> 3), 8'(i * 8 + 1)));
        send_piece(CMD_ADD, piece(3'd6, 3'd6, 8'hEE));
        send_piece(CMD_ADD, piece(3'd1, 3'd0, 8'd9));
        send_piece(CMD_REMOVE, piece(3'd1, 3'd2, 8'(17 * 8 + 1)));
        send_piece(CMD_ADD, piece(3'd6, 3'd6, 8'hEE));
        send_piece(CMD_FIND, piece(3'd6, 3'd6, 8'hEE));
        send_piece(CMD_REMOVE, piece(3'd7, 3'd3, 8'(31 * 8 + 1)));
        send_piece(CMD_CLEAR, '0);
    endtask

    // The result side holds off for a long stretch while commands keep coming, so
    // the block fills up and holds its input; then the sender waits for every result.
    task automatic test_output_backpressure();
        int i;
        hold_request = 300;
        for (i = 0; i < 10; i++)
            send_piece((i % 2 == 0) ? CMD_ADD : CMD_FIND, choose_key(50));
        wait_for_replies();
        send_piece(CMD_REMOVE, choose_key(90));
        send_piece(CMD_FIND, choose_key(90));
        wait_for_replies();
    endtask

    // Random traffic: a burst of adds that usually runs the pool full, then a mix
    // of finds, adds and removes on mostly chained pieces, with the odd clear.
    task automatic test_random_mix(input int count);
        int i;
        int r;
        for (i = 0; i < 36; i++)
            send_piece(CMD_ADD, choose_key(10));
        for (i = 36; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 35)
                send_piece(CMD_FIND, choose_key(70));
            else if (r < 65)
                send_piece(CMD_ADD, choose_key(25));
            else if (r < 98)
                send_piece(CMD_REMOVE, choose_key(70));
            else
                send_piece(CMD_CLEAR, choose_key(0));
        end
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        m_tready <= 1'b0;
        reset_table_model();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 24;
        recv_idle_pct = 57;
        test_empty_table();
        test_single_entry();
        test_chain_order();
        test_pool_full();
        test_output_backpressure();
        test_random_mix(110);

        send_idle_pct = 57;
        recv_idle_pct = 24;
        test_random_mix(110);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(110);

        // Drain, then keep watching for any stray transfer before the verdict.
        wait_for_replies();
        repeat (SLOTS + 8) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
